FILE: hw/rtl/breakpoint_match_table_assert.svh
// assertion macros for the breakpoint match table rtl
`ifndef BREAKPOINT_MATCH_TABLE_ASSERT_SVH
`define BREAKPOINT_MATCH_TABLE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BMT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("breakpoint table check failed");

// next-cycle implication, checked out of reset
`define BMT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("breakpoint table check failed");

`endif

FILE: hw/rtl/bmt_pkg.sv
// shared types and constants for the breakpoint match table
package bmt_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int ADDR_W  = 16;
  localparam int OPC_W   = 8;
  localparam int HIDX_W  = 4;

  localparam logic [1:0] OP_SET   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_CHECK = 2'd2;

  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] address;
    logic [OPC_W-1:0]  opcode_byte;
    logic              want_temporary;
    logic              want_opcode_match;
  } in_word_t;

  typedef struct packed {
    logic              success;
    logic [HIDX_W-1:0] hit_index;
  } out_word_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } lookup_t;

endpackage

FILE: hw/rtl/breakpoint_match_table.sv
// top level of the breakpoint match table: input register, entry table, result register
//
//  channel  | handshake            | payload                       | direction
//  ---------+----------------------+-------------------------------+----------
//  input    | in_valid / in_ready  | in_word   (bmt_pkg::in_word_t)  | in
//  result   | out_valid / out_ready| out_word  (bmt_pkg::out_word_t) | out
//
// one word accepted per cycle unless a stalled result backs up the input register, one result word per input word
// a word passes the input register, then compare/select into the result register
// the table updates on the same edge the result is registered, so the next word sees it
// a stalled result holds the input register; ready falls only when both stages are full
// reset clears the valid, temporary and opcode flags of every entry; values stay unknown
module breakpoint_match_table (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bmt_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output bmt_pkg::out_word_t  out_word
);
  import bmt_pkg::*;

`include "breakpoint_match_table_assert.svh"

  // input stage
  logic     s1_valid_r;
  in_word_t s1_word_r;
  logic     s1_adv;
  logic     s1_fire;

  // entry table
  logic [ADDR_W-1:0]  entry_value_r [ENTRIES];
  logic [ENTRIES-1:0] entry_valid_r;
  logic [ENTRIES-1:0] entry_temp_r;
  logic [ENTRIES-1:0] entry_opk_r;

  // result stage
  logic      out_valid_r;
  out_word_t out_r;
  out_word_t out_nxt;

  lookup_t lk;
  logic    do_set;
  logic    do_inval;

  // stage 1 moves whenever the result register is empty or draining
  assign s1_adv   = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && s1_adv;
  assign in_ready = !s1_valid_r || s1_adv;

  bmt_lookup u_lookup (
    .word        (s1_word_r),
    .entry_value (entry_value_r),
    .entry_valid (entry_valid_r),
    .entry_opk   (entry_opk_r),
    .result      (lk)
  );

  // a clear that finds its entry, or a hit on a temporary entry, drops it
  always_comb begin
    do_set   = 1'b0;
    do_inval = 1'b0;
    unique case (s1_word_r.op)
      OP_SET:   do_set   = lk.found;
      OP_CLEAR: do_inval = lk.found;
      OP_CHECK: do_inval = lk.found && entry_temp_r[lk.idx];
      default: ;
    endcase
  end

  always_comb begin
    out_nxt.success   = lk.found;
    out_nxt.hit_index = (s1_word_r.op == OP_CHECK && lk.found) ? HIDX_W'(lk.idx) : '0;
  end

  // control and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      entry_valid_r <= '0;
      entry_temp_r  <= '0;
      entry_opk_r   <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_fire && do_set) begin
        entry_valid_r[lk.idx] <= 1'b1;
        entry_temp_r[lk.idx]  <= s1_word_r.want_temporary;
        entry_opk_r[lk.idx]   <= s1_word_r.want_opcode_match;
      end else if (s1_fire && do_inval) begin
        entry_valid_r[lk.idx] <= 1'b0;
        entry_temp_r[lk.idx]  <= 1'b0;
        entry_opk_r[lk.idx]   <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_word_r <= in_word;
    end
    if (s1_fire) begin
      out_r <= out_nxt;
    end
    if (s1_fire && do_set) begin
      entry_value_r[lk.idx] <= s1_word_r.address;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // a set that fails only when every entry is taken
  `BMT_ASSERT_NOW(a_set_full, s1_fire && s1_word_r.op == OP_SET && !lk.found, &entry_valid_r)
  // a stored entry is valid afterwards
  `BMT_ASSERT_NEXT(a_set_valid, s1_fire && do_set, entry_valid_r[$past(lk.idx)])
  // a cleared entry is gone afterwards
  `BMT_ASSERT_NEXT(a_clr_gone, s1_fire && do_inval, !entry_valid_r[$past(lk.idx)])
  // a failed lookup never reports an index
  `BMT_ASSERT_NOW(a_idx_zero, out_valid_r && !out_r.success, out_r.hit_index == '0)

endmodule

FILE: hw/rtl/bmt_lookup.sv
// parallel compare of all entries and lowest-index selection per operation
module bmt_lookup (
  input  bmt_pkg::in_word_t                 word,
  input  logic [bmt_pkg::ADDR_W-1:0]        entry_value [bmt_pkg::ENTRIES],
  input  logic [bmt_pkg::ENTRIES-1:0]       entry_valid,
  input  logic [bmt_pkg::ENTRIES-1:0]       entry_opk,
  output bmt_pkg::lookup_t                  result
);
  import bmt_pkg::*;

  logic [ENTRIES-1:0] free_v;
  logic [ENTRIES-1:0] addr_eq_v;
  logic [ENTRIES-1:0] chk_v;
  logic [ENTRIES-1:0] sel_v;
  logic [ADDR_W-1:0]  opc_ext;

  assign opc_ext = {{(ADDR_W-OPC_W){1'b0}}, word.opcode_byte};

  always_comb begin
    for (int k = 0; k < ENTRIES; k++) begin
      free_v[k]    = !entry_valid[k];
      addr_eq_v[k] = entry_valid[k] && (entry_value[k] == word.address);
      chk_v[k]     = addr_eq_v[k] ||
                     (entry_valid[k] && entry_opk[k] && (entry_value[k] == opc_ext));
    end
  end

  always_comb begin
    unique case (word.op)
      OP_SET:   sel_v = free_v;
      OP_CLEAR: sel_v = addr_eq_v;
      OP_CHECK: sel_v = chk_v;
      default:  sel_v = '0;
    endcase
  end

  // lowest set bit wins
  always_comb begin
    result = '0;
    for (int k = ENTRIES-1; k >= 0; k--) begin
      if (sel_v[k]) begin
        result.found = 1'b1;
        result.idx   = IDX_W'(k);
      end
    end
  end

endmodule

FILE: verif/tb_breakpoint_match_table.sv
// testbench for the breakpoint match table: directed table then random traffic vs a table model
`timescale 1ns / 100ps

module tb_breakpoint_match_table;
  import bmt_pkg::*;

  // op code the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_WORDS = 1720;
  localparam int QUIET_LIMIT  = 2000;
  localparam int LONG_HOLD    = 40;

  // one line of the directed table: the word, and its result where it is obvious
  typedef struct {
    in_word_t  w;
    bit        known;
    out_word_t result;
  } dir_row_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  // shadow copy of the breakpoint table
  logic [ADDR_W-1:0] bp_value [ENTRIES];
  bit                bp_live  [ENTRIES];
  bit                bp_oneshot [ENTRIES];
  bit                bp_opk   [ENTRIES];

  out_word_t pending_results[$];
  int        mismatch_count = 0;
  int        quiet_cycles   = 0;

  // traffic shaping flags, set by the sender
  bit calm         = 1'b0;
  bit flood        = 1'b0;
  bit hold_request = 1'b0;

  breakpoint_match_table u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // table model: applies one word to the shadow table and returns its result word
  function automatic out_word_t apply_table_op(in_word_t w);
    out_word_t r;
    bit        done;
    bit        hit;
    r    = '0;
    done = 1'b0;
    case (w.op)
      OP_SET: begin
        // lowest free slot takes the new breakpoint
        for (int k = 0; k < ENTRIES && !done; k++) begin
          if (!bp_live[k]) begin
            bp_value[k]   = w.address;
            bp_live[k]    = 1'b1;
            bp_oneshot[k] = w.want_temporary;
            bp_opk[k]     = w.want_opcode_match;
            r.success     = 1'b1;
            done          = 1'b1;
          end
        end
      end
      OP_CLEAR: begin
        for (int k = 0; k < ENTRIES && !done; k++) begin
          if (bp_live[k] && bp_value[k] == w.address) begin
            bp_live[k]    = 1'b0;
            bp_oneshot[k] = 1'b0;
            bp_opk[k]     = 1'b0;
            r.success     = 1'b1;
            done          = 1'b1;
          end
        end
      end
      OP_CHECK: begin
        // opcode byte is zero-extended, so values above 0xff never match it
        for (int k = 0; k < ENTRIES && !done; k++) begin
          hit = bp_live[k] && (bp_value[k] == w.address ||
                (bp_opk[k] && bp_value[k] == {8'h00, w.opcode_byte}));
          if (hit) begin
            if (bp_oneshot[k]) begin
              bp_live[k]    = 1'b0;
              bp_oneshot[k] = 1'b0;
              bp_opk[k]     = 1'b0;
            end
            r.success   = 1'b1;
            r.hit_index = HIDX_W'(k);
            done        = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // value of a random live entry, or any value when the table is empty
  function automatic logic [ADDR_W-1:0] live_value();
    int live[$];
    for (int k = 0; k < ENTRIES; k++)
      if (bp_live[k]) live.push_back(k);
    if (live.size() == 0) return ADDR_W'($urandom);
    return bp_value[live[$urandom_range(0, live.size() - 1)]];
  endfunction

  // opcode byte that hits a live opcode entry, if there is one
  function automatic logic [OPC_W-1:0] opcode_target();
    int cand[$];
    for (int k = 0; k < ENTRIES; k++)
      if (bp_live[k] && bp_opk[k] && bp_value[k] <= 16'h00ff) cand.push_back(k);
    if (cand.size() == 0) return OPC_W'($urandom);
    return bp_value[cand[$urandom_range(0, cand.size() - 1)]][OPC_W-1:0];
  endfunction

  // random word, mostly aimed at values that are live in the table
  function automatic in_word_t random_word(int set_pct, int clear_pct);
    in_word_t w;
    int       roll;
    roll = $urandom_range(0, 99);
    if (roll < set_pct) w.op = OP_SET;
    else if (roll < set_pct + clear_pct) w.op = OP_CLEAR;
    else if (roll < 96) w.op = OP_CHECK;
    else w.op = OP_UNUSED;
    w.want_temporary    = ($urandom_range(0, 2) == 0);
    w.want_opcode_match = 1'($urandom_range(0, 1));
    w.opcode_byte       = OPC_W'($urandom_range(0, 255));
    roll = $urandom_range(0, 9);
    if (w.op == OP_SET) begin
      // small values make opcode hits possible, repeats make duplicate entries
      if (roll < 4) w.address = ADDR_W'($urandom_range(0, 255));
      else if (roll < 6) w.address = live_value();
      else w.address = ADDR_W'($urandom_range(0, 65535));
    end else begin
      if (roll < 6) w.address = live_value();
      else if (roll < 8) w.address = ADDR_W'($urandom_range(0, 255));
      else w.address = ADDR_W'($urandom_range(0, 65535));
      if ($urandom_range(0, 1) == 1) w.opcode_byte = opcode_target();
    end
    return w;
  endfunction

  function automatic dir_row_t make_row(logic [1:0] op, logic [ADDR_W-1:0] addr,
                                        logic [OPC_W-1:0] opc, bit tmp, bit opk,
                                        bit known, bit ok, logic [HIDX_W-1:0] idx);
    dir_row_t r;
    r.w.op                = op;
    r.w.address           = addr;
    r.w.opcode_byte       = opc;
    r.w.want_temporary    = tmp;
    r.w.want_opcode_match = opk;
    r.known               = known;
    r.result.success      = ok;
    r.result.hit_index    = idx;
    return r;
  endfunction

  // offer one word, hold it until taken, then book its result word
  task automatic push_word(input in_word_t w, input bit known, input out_word_t typed);
    out_word_t predicted;
    if (!calm && !flood && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // taken at this edge: the model moves on in step with the block
    predicted = apply_table_op(w);
    pending_results.push_back(known ? typed : predicted);
  endtask

  // sender
  initial begin
    dir_row_t rows[$];
    int       set_pct;
    for (int k = 0; k < ENTRIES; k++) begin
      bp_value[k]   = '0;
      bp_live[k]    = 1'b0;
      bp_oneshot[k] = 1'b0;
      bp_opk[k]     = 1'b0;
    end
    set_pct = 30;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: nothing hits, nothing to clear, unused op does nothing
    rows.push_back(make_row(OP_CHECK, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 4'd0));
    rows.push_back(make_row(OP_CLEAR, 16'hffff, 8'hff, 1'b1, 1'b1, 1'b1, 1'b0, 4'd0));
    rows.push_back(make_row(OP_UNUSED, 16'hffff, 8'hff, 1'b1, 1'b1, 1'b1, 1'b0, 4'd0));
    // plain entry in slot 0, one-shot opcode entry in slot 1
    rows.push_back(make_row(OP_SET, 16'hffff, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 4'd0));
    rows.push_back(make_row(OP_SET, 16'h00ff, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 4'd0));
    // opcode hit on slot 1, which then drops out
    rows.push_back(make_row(OP_CHECK, 16'h1234, 8'hff, 1'b0, 1'b0, 1'b1, 1'b1, 4'd1));
    rows.push_back(make_row(OP_CHECK, 16'h1234, 8'hff, 1'b0, 1'b0, 1'b1, 1'b0, 4'd0));
    // opcode entry above 0xff must not match opcode byte 0x00
    rows.push_back(make_row(OP_SET, 16'h0100, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 4'd0));
    rows.push_back(make_row(OP_CHECK, 16'h1234, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 4'd0));
    rows.push_back(make_row(OP_CLEAR, 16'hffff, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 4'd0));
    // fill every free slot, then one set too many
    for (int k = 0; k < ENTRIES - 1; k++)
      rows.push_back(make_row(OP_SET, ADDR_W'(k * 16'h1111), OPC_W'(k), k[0], k[1],
                              1'b1, 1'b1, 4'd0));
    rows.push_back(make_row(OP_SET, 16'h4321, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 4'd0));
    // full table lookups, left to the model
    rows.push_back(make_row(OP_CHECK, 16'heeee, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0));
    rows.push_back(make_row(OP_CHECK, 16'h5555, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0));

    foreach (rows[i]) push_word(rows[i].w, rows[i].known, rows[i].result);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      // every so often lean the mix toward filling or toward emptying
      if (i % 64 == 0) set_pct = $urandom_range(10, 50);
      // let the block run dry before carrying on
      if (i == 0 || i == 300 || i == 1100) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      // long result stall while words keep coming, so the input backs up
      if (i == 700) hold_request = 1'b1;
      flood = (i >= 700 && i < 740);
      calm  = (i >= 1500);
      push_word(random_word(set_pct, 55 - set_pct), 1'b0, '0);
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d result words never arrived", pending_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // receiver: random short stalls, one long hold on request, none when calm
  int stall_left = 0;
  bit hold_taken = 1'b0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (hold_request && !hold_taken) begin
      out_ready  <= 1'b0;
      stall_left = LONG_HOLD - 1;
      hold_taken = 1'b1;
    end else if (!calm && $urandom_range(0, 6) == 0) begin
      out_ready  <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result checker: each result word against the oldest booked one
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result word arrived with nothing pending");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_word.success !== want.success) begin
          $error("success: expected %0d, got %0d", want.success, out_word.success);
          mismatch_count++;
        end
        if (out_word.hit_index !== want.hit_index) begin
          $error("hit_index: expected %0d, got %0d", want.hit_index, out_word.hit_index);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule
